// ===== hdl/cuckoo_hash_table_engine_macros.svh =====
// assertion macros for the cuckoo hash table engine checker
`ifndef CUCKOO_HASH_TABLE_ENGINE_MACROS_SVH
`define CUCKOO_HASH_TABLE_ENGINE_MACROS_SVH

// assert that a condition implies a result in the same cycle
`define CHT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// assert that a condition implies a result in the next cycle
`define CHT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/chte_pkg.sv =====
// shared types and constants for the cuckoo hash table engine
package chte_pkg;

  localparam int TableDepth    = 1024;
  localparam int MaxEvictDepth = 64;
  localparam int BlockBytes    = 16384;
  localparam int SlotW         = $clog2(TableDepth);
  localparam int CountW        = SlotW + 1;
  localparam int StackW        = $clog2(MaxEvictDepth);
  localparam int DepthW        = 7;

  // slot record stored in one memory word
  typedef struct packed {
    logic [127:0] key;
    logic [31:0]  seq;
    logic [15:0]  flags;
    logic [14:0]  size;
  } slot_rec_t;

  localparam int RecW = $bits(slot_rec_t);

  typedef enum logic [1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_WRITE  = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_FLAGS  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_READ_ONLY = 3'd2,
    ST_FULL      = 3'd3,
    ST_TOO_LARGE = 3'd4,
    ST_ZERO_KEY  = 3'd5
  } status_t;

  localparam int FlagSticky   = 0;
  localparam int FlagReadOnly = 1;

  localparam logic [1:0] CfgTableCount = 2'd0;
  localparam logic [1:0] CfgDepthLimit = 2'd1;

  // request to the modulo unit
  typedef struct packed {
    logic        start;
    logic [31:0] word;
  } mod_req_t;

  // answer from the modulo unit
  typedef struct packed {
    logic             done;
    logic [SlotW-1:0] pos;
  } mod_rsp_t;

endpackage

// ===== hdl/chte_ram.sv =====
// generic single-port ram with registered read
module chte_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== hdl/chte_mod.sv =====
// bit-serial remainder of a 32-bit word by the active slot count
module chte_mod (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [chte_pkg::CountW-1:0] divisor,
  input  chte_pkg::mod_req_t        req,
  output chte_pkg::mod_rsp_t        rsp
);
  import chte_pkg::*;

  logic [31:0]     word_r, word_nxt;
  logic [CountW:0] rem_r, rem_nxt;
  logic [5:0]      cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CountW:0] shifted;

  always_comb begin
    word_nxt = word_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r[CountW-1:0], word_r[31]};
    if (req.start) begin
      word_nxt = req.word;
      rem_nxt  = '0;
      cnt_nxt  = 6'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // one quotient bit a cycle
      rem_nxt  = (shifted >= {1'b0, divisor}) ? shifted - {1'b0, divisor} : shifted;
      word_nxt = {word_r[30:0], 1'b0};
      cnt_nxt  = cnt_r + 6'd1;
      if (cnt_r == 6'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    word_r <= word_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.pos  = rem_r[SlotW-1:0];
endmodule

// ===== hdl/cuckoo_hash_table_engine.sv =====
// top level of the four-way cuckoo hash table engine
// usage:
//   input channel in_* carries one request per item: a mode (lookup, write,
//   delete, set flags), a 128-bit key, flags, a flag mask and a data size.
//   output channel out_* returns exactly one result per request: status,
//   slot, the entry's sequence, flags and size, a drop marker and the fill.
//   cfg_* writes table_count (index 0) and depth_limit (index 1); the user
//   makes these writes only while idle, the block does not enforce it.
// sequencing:
//   one request at a time. each slot position is a serial remainder in the
//   modulo unit then a table read; a lookup probes up to four of them. a
//   write that must evict walks a chain of up to depth_limit levels per
//   candidate, computing and reading the alternates at each level. the
//   modulo unit and the single table port set the pace.
// reset:
//   rst_n clears control state, then a clearing pass writes every one of the
//   1024 slots to empty, during which in_tready stays low.
// stall:
//   the result sits in an output register; when out_tready is low the block
//   holds it and accepts no new request until it is taken.
module cuckoo_hash_table_engine (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // mode[1:0], key_word0..3[129:2], user_flags[145:130], flag_mask[161:146],
  // data_size[176:162], zero pad to 184 bits
  input  logic [183:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[2:0], slot[12:3], entry_seq[44:13], entry_flags[60:45],
  // entry_size[75:61], dropped[76], fill[87:77], zero pad to 88 bits
  output logic [87:0]  out_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [10:0]  cfg_wdata
);
  import chte_pkg::*;

  // sequencer states
  typedef enum logic [22:0] {
    S_CLEAR  = 23'd1 << 0,
    S_IDLE   = 23'd1 << 1,
    S_CAND   = 23'd1 << 2,   // compute candidate position cand_i
    S_CRD    = 23'd1 << 3,   // read candidate slot
    S_CCHK   = 23'd1 << 4,   // check candidate for the selected mode
    S_EV0    = 23'd1 << 5,   // start an eviction chain at candidate cand_i
    S_ERD    = 23'd1 << 6,   // read cur
    S_EWAIT  = 23'd1 << 7,
    S_EALT   = 23'd1 << 8,   // compute alternate position of cur word alt_i
    S_EARD   = 23'd1 << 9,   // read alternate
    S_EACHK  = 23'd1 << 10,  // empty alternate check
    S_EMOVE  = 23'd1 << 11,  // write cur into alternate
    S_ECLR   = 23'd1 << 12,  // clear cur
    S_EDROP  = 23'd1 << 13,  // push a level or start the drop scan
    S_EDRD   = 23'd1 << 14,
    S_EDCHK  = 23'd1 << 15,
    S_UNW    = 23'd1 << 16,  // pop a level
    S_URD    = 23'd1 << 17,  // read popped slot
    S_UWAIT  = 23'd1 << 18,
    S_UCOPY  = 23'd1 << 19,  // copy popped into child
    S_PLACE  = 23'd1 << 20,  // store the new key at the candidate
    S_RESULT = 23'd1 << 21,
    S_STK    = 23'd1 << 22   // stack read wait
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [10:0] table_count_r;
  logic [6:0]  depth_limit_r;
  logic [CountW-1:0] act_count;
  logic [DepthW-1:0] act_depth;

  always_comb begin
    if (table_count_r == 11'd0) act_count = CountW'(1);
    else if (table_count_r > 11'(TableDepth)) act_count = CountW'(TableDepth);
    else act_count = table_count_r[CountW-1:0];
    act_depth = (depth_limit_r > 7'(MaxEvictDepth)) ? 7'(MaxEvictDepth) : depth_limit_r;
  end

  // request fields
  logic [1:0]   mode_r;
  logic [127:0] key_r;
  logic [15:0]  uf_r, fm_r;
  logic [14:0]  ds_r;

  // working registers
  logic [1:0]       cand_i_r, cand_i_nxt;
  logic [1:0]       alt_i_r, alt_i_nxt;
  logic [2:0]       phase_r, phase_nxt;  // 0 probe, 1 evict pass
  logic [SlotW-1:0] pos_r, pos_nxt;      // candidate position
  logic [SlotW-1:0] cur_r, cur_nxt;
  logic [SlotW-1:0] alt_r, alt_nxt;
  logic [SlotW-1:0] child_r, child_nxt;
  logic [DepthW-1:0] d_r, d_nxt;
  logic             ok_r, ok_nxt;
  logic             unw_r, unw_nxt;       // unwinding with drop scan on pop
  slot_rec_t        cur_rec_r, cur_rec_nxt;
  slot_rec_t        pop_rec_r, pop_rec_nxt;
  logic [CountW-1:0] fill_r, fill_nxt;
  logic             drop_r, drop_nxt;
  logic [SlotW:0]   clr_r, clr_nxt;

  // output register
  logic        ovalid_r, ovalid_nxt;
  logic [87:0] odata_r, odata_nxt;

  // table memory
  logic             ram_we;
  logic [SlotW-1:0] ram_addr;
  slot_rec_t        ram_wdata, ram_rdata;

  chte_ram #(.Width(RecW), .Depth(TableDepth)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // eviction stack memory
  logic              stk_we;
  logic [StackW-1:0] stk_addr;
  logic [SlotW-1:0]  stk_wdata, stk_rdata;

  chte_ram #(.Width(SlotW), .Depth(MaxEvictDepth)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .addr  (stk_addr),
    .wdata (stk_wdata),
    .rdata (stk_rdata)
  );

  // modulo unit
  mod_req_t mreq;
  mod_rsp_t mrsp;

  chte_mod u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .divisor (act_count),
    .req     (mreq),
    .rsp     (mrsp)
  );

  logic mod_wait_r, mod_wait_nxt;

  function automatic logic [31:0] key_word(input logic [127:0] k, input logic [1:0] i);
    logic [31:0] w;
    case (i)
      2'd0:    w = k[31:0];
      2'd1:    w = k[63:32];
      2'd2:    w = k[95:64];
      default: w = k[127:96];
    endcase
    return w;
  endfunction

  logic in_fire, out_fire;
  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;
  assign in_tready  = (state_r == S_IDLE) && !ovalid_r;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;

  // result packing
  function automatic logic [87:0] pack(input status_t st, input logic rep,
                                       input logic [SlotW-1:0] at, input slot_rec_t r,
                                       input logic dr, input logic [CountW-1:0] f);
    logic [87:0] o;
    o = '0;
    o[2:0] = st;
    if (rep) begin
      o[12:3]  = at;
      o[44:13] = r.seq;
      o[60:45] = r.flags;
      o[75:61] = r.size;
    end
    o[76]    = dr;
    o[87:77] = f;
    return o;
  endfunction

  logic rd_empty, rd_match, cur_empty;
  assign rd_empty = (ram_rdata.key == '0);
  assign rd_match = (ram_rdata.key == key_r);

  slot_rec_t new_rec;

  always_comb begin
    state_nxt    = state_r;
    cand_i_nxt   = cand_i_r;
    alt_i_nxt    = alt_i_r;
    phase_nxt    = phase_r;
    pos_nxt      = pos_r;
    cur_nxt      = cur_r;
    alt_nxt      = alt_r;
    child_nxt    = child_r;
    d_nxt        = d_r;
    ok_nxt       = ok_r;
    unw_nxt      = unw_r;
    cur_rec_nxt  = cur_rec_r;
    pop_rec_nxt  = pop_rec_r;
    fill_nxt     = fill_r;
    drop_nxt     = drop_r;
    clr_nxt      = clr_r;
    ovalid_nxt   = ovalid_r;
    odata_nxt    = odata_r;
    mod_wait_nxt = mod_wait_r;
    ram_we       = 1'b0;
    ram_addr     = pos_r;
    ram_wdata    = '0;
    stk_we       = 1'b0;
    stk_addr     = d_r[StackW-1:0];
    stk_wdata    = cur_r;
    mreq.start   = 1'b0;
    mreq.word    = key_word(key_r, cand_i_r);
    cur_empty    = (cur_rec_r.key == '0);
    new_rec      = '0;

    if (out_fire) ovalid_nxt = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_r[SlotW-1:0];
        clr_nxt  = clr_r + 1'b1;
        if (clr_r == (SlotW+1)'(TableDepth - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          drop_nxt   = 1'b0;
          cand_i_nxt = 2'd0;
          phase_nxt  = 3'd0;
          if (in_tdata[1:0] == MODE_WRITE && in_tdata[176:162] > 15'(BlockBytes)) begin
            ovalid_nxt = 1'b1;
            odata_nxt  = pack(ST_TOO_LARGE, 1'b0, '0, '0, 1'b0, fill_r);
          end else if (in_tdata[129:2] == '0) begin
            ovalid_nxt = 1'b1;
            odata_nxt  = pack(ST_ZERO_KEY, 1'b0, '0, '0, 1'b0, fill_r);
          end else begin
            state_nxt    = S_CAND;
            mod_wait_nxt = 1'b0;
          end
        end
      end
      S_CAND: begin
        // launch the remainder once, then wait for it
        if (!mod_wait_r) begin
          mreq.start   = 1'b1;
          mod_wait_nxt = 1'b1;
        end else if (mrsp.done) begin
          mod_wait_nxt = 1'b0;
          pos_nxt      = mrsp.pos;
          state_nxt    = (phase_r == 3'd0) ? S_CRD : S_EV0;
        end
      end
      S_CRD: begin
        ram_addr  = pos_r;
        state_nxt = S_CCHK;
      end
      S_CCHK: begin
        if (mode_r == MODE_WRITE) begin
          if (rd_empty || rd_match) begin
            if (rd_match && ram_rdata.flags[FlagReadOnly]) begin
              ovalid_nxt = 1'b1;
              odata_nxt  = pack(ST_READ_ONLY, 1'b1, pos_r, ram_rdata, 1'b0, fill_r);
              state_nxt  = S_IDLE;
            end else begin
              new_rec.key   = key_r;
              new_rec.seq   = rd_empty ? 32'd1 : ram_rdata.seq + 32'd1;
              new_rec.flags = uf_r;
              new_rec.size  = ds_r;
              ram_we    = 1'b1;
              ram_addr  = pos_r;
              ram_wdata = new_rec;
              if (rd_empty) fill_nxt = fill_r + 1'b1;
              ovalid_nxt = 1'b1;
              odata_nxt  = pack(ST_OK, 1'b1, pos_r, new_rec, 1'b0,
                                rd_empty ? fill_r + 1'b1 : fill_r);
              state_nxt  = S_IDLE;
            end
          end else if (cand_i_r == 2'd3) begin
            // no free or matching candidate: start evicting
            phase_nxt  = 3'd1;
            cand_i_nxt = 2'd0;
            state_nxt  = S_CAND;
          end else begin
            cand_i_nxt = cand_i_r + 2'd1;
            state_nxt  = S_CAND;
          end
        end else begin
          if (rd_match) begin
            new_rec = ram_rdata;
            if (mode_r == MODE_DELETE) begin
              new_rec  = '0;
              ram_we   = 1'b1;
              if (fill_r != '0) fill_nxt = fill_r - 1'b1;
              odata_nxt = pack(ST_OK, 1'b1, pos_r, new_rec, 1'b0,
                               (fill_r != '0) ? fill_r - 1'b1 : fill_r);
            end else if (mode_r == MODE_FLAGS) begin
              new_rec.flags = (ram_rdata.flags & ~fm_r) | (uf_r & fm_r);
              ram_we   = 1'b1;
              odata_nxt = pack(ST_OK, 1'b1, pos_r, new_rec, 1'b0, fill_r);
            end else begin
              odata_nxt = pack(ST_OK, 1'b1, pos_r, new_rec, 1'b0, fill_r);
            end
            ram_addr   = pos_r;
            ram_wdata  = new_rec;
            ovalid_nxt = 1'b1;
            state_nxt  = S_IDLE;
          end else if (cand_i_r == 2'd3) begin
            ovalid_nxt = 1'b1;
            odata_nxt  = pack(ST_NOT_FOUND, 1'b0, '0, '0, 1'b0, fill_r);
            state_nxt  = S_IDLE;
          end else begin
            cand_i_nxt = cand_i_r + 2'd1;
            state_nxt  = S_CAND;
          end
        end
      end
      S_EV0: begin
        cur_nxt   = pos_r;
        d_nxt     = '0;
        state_nxt = S_ERD;
      end
      S_ERD: begin
        // new level: check depth then read cur
        if (d_r >= act_depth) begin
          ok_nxt    = 1'b0;
          child_nxt = cur_r;
          state_nxt = S_UNW;
        end else begin
          ram_addr  = cur_r;
          state_nxt = S_EWAIT;
        end
      end
      S_EWAIT: begin
        cur_rec_nxt  = ram_rdata;
        alt_i_nxt    = 2'd0;
        mod_wait_nxt = 1'b0;
        unw_nxt      = 1'b0;
        state_nxt    = S_EALT;
      end
      S_EALT: begin
        mreq.word = key_word(cur_rec_r.key, alt_i_r);
        if (!mod_wait_r) begin
          mreq.start   = 1'b1;
          mod_wait_nxt = 1'b1;
        end else if (mrsp.done) begin
          mod_wait_nxt = 1'b0;
          alt_nxt      = mrsp.pos;
          if (alt_i_r == 2'd0) child_nxt = mrsp.pos;  // first alternate kept
          if (mrsp.pos == cur_r) begin
            if (alt_i_r == 2'd3) state_nxt = S_EDROP;
            else alt_i_nxt = alt_i_r + 2'd1;
          end else begin
            state_nxt = S_EARD;
          end
        end
      end
      S_EARD: begin
        ram_addr  = alt_r;
        state_nxt = S_EACHK;
      end
      S_EACHK: begin
        if (ram_rdata.key == '0) begin
          state_nxt = S_EMOVE;
        end else if (alt_i_r == 2'd3) begin
          state_nxt = S_EDROP;
        end else begin
          alt_i_nxt = alt_i_r + 2'd1;
          state_nxt = S_EALT;
        end
      end
      S_EMOVE: begin
        ram_we    = 1'b1;
        ram_addr  = alt_r;
        ram_wdata = cur_rec_r;
        state_nxt = S_ECLR;
      end
      S_ECLR: begin
        ram_we    = 1'b1;
        ram_addr  = cur_r;
        ram_wdata = '0;
        if (unw_r) begin
          // copy during unwind or drop completed
          child_nxt = cur_r;
          state_nxt = S_UNW;
        end else begin
          ok_nxt    = 1'b1;
          child_nxt = cur_r;
          state_nxt = S_UNW;
        end
      end
      S_EDROP: begin
        // decide between pushing a level and dropping
        if (!unw_r && child_r != cur_r) begin
          stk_we    = 1'b1;
          stk_addr  = d_r[StackW-1:0];
          stk_wdata = cur_r;
          cur_nxt   = child_r;
          d_nxt     = d_r + 1'b1;
          state_nxt = S_ERD;
        end else begin
          alt_i_nxt    = 2'd0;
          mod_wait_nxt = 1'b0;
          state_nxt    = S_EDRD;
        end
      end
      S_EDRD: begin
        // drop scan: compute alternate, then read its flags
        mreq.word = key_word(cur_rec_r.key, alt_i_r);
        if (!mod_wait_r) begin
          mreq.start   = 1'b1;
          mod_wait_nxt = 1'b1;
        end else if (mrsp.done) begin
          mod_wait_nxt = 1'b0;
          alt_nxt      = mrsp.pos;
          if (mrsp.pos == cur_r) begin
            if (alt_i_r == 2'd3) begin
              ok_nxt    = 1'b0;
              child_nxt = cur_r;
              state_nxt = S_UNW;
            end else begin
              alt_i_nxt = alt_i_r + 2'd1;
            end
          end else begin
            ram_addr  = mrsp.pos;
            state_nxt = S_EDCHK;
          end
        end
      end
      S_EDCHK: begin
        if (ram_rdata.flags[FlagSticky]) begin
          if (alt_i_r == 2'd3) begin
            ok_nxt    = 1'b0;
            child_nxt = cur_r;
            state_nxt = S_UNW;
          end else begin
            alt_i_nxt = alt_i_r + 2'd1;
            state_nxt = S_EDRD;
          end
        end else begin
          if (fill_r != '0) fill_nxt = fill_r - 1'b1;
          drop_nxt  = 1'b1;
          ok_nxt    = 1'b1;
          unw_nxt   = 1'b1;
          state_nxt = S_EMOVE;
        end
      end
      S_UNW: begin
        if (d_r == '0) begin
          if (ok_r) begin
            state_nxt = S_PLACE;
          end else if (cand_i_r == 2'd3) begin
            ovalid_nxt = 1'b1;
            odata_nxt  = pack(ST_FULL, 1'b0, '0, '0, drop_r, fill_r);
            state_nxt  = S_IDLE;
          end else begin
            cand_i_nxt = cand_i_r + 2'd1;
            state_nxt  = S_CAND;
          end
        end else begin
          d_nxt     = d_r - 1'b1;
          stk_addr  = 6'(d_r - 1'b1);
          state_nxt = S_STK;
        end
      end
      S_STK: begin
        cur_nxt   = stk_rdata;
        ram_addr  = stk_rdata;
        state_nxt = S_UWAIT;
      end
      S_UWAIT: begin
        cur_rec_nxt = ram_rdata;
        if (ok_r) begin
          state_nxt = S_UCOPY;
        end else begin
          unw_nxt   = 1'b1;
          state_nxt = S_EDROP;
        end
      end
      S_UCOPY: begin
        ram_we    = 1'b1;
        ram_addr  = child_r;
        ram_wdata = cur_rec_r;
        unw_nxt   = 1'b1;
        state_nxt = S_ECLR;
      end
      S_PLACE: begin
        new_rec.key   = key_r;
        new_rec.seq   = 32'd1;
        new_rec.flags = uf_r;
        new_rec.size  = ds_r;
        ram_we     = 1'b1;
        ram_addr   = pos_r;
        ram_wdata  = new_rec;
        fill_nxt   = fill_r + 1'b1;
        ovalid_nxt = 1'b1;
        odata_nxt  = pack(ST_OK, 1'b1, pos_r, new_rec, drop_r, fill_r + 1'b1);
        state_nxt  = S_IDLE;
      end
      S_RESULT: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (cur_empty && 1'b0) state_nxt = state_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_r         <= '0;
      fill_r        <= '0;
      ovalid_r      <= 1'b0;
      mod_wait_r    <= 1'b0;
      table_count_r <= 11'(TableDepth);
      depth_limit_r <= 7'(MaxEvictDepth);
    end else begin
      state_r    <= state_nxt;
      clr_r      <= clr_nxt;
      fill_r     <= fill_nxt;
      ovalid_r   <= ovalid_nxt;
      mod_wait_r <= mod_wait_nxt;
      if (cfg_we && cfg_index == CfgTableCount) table_count_r <= cfg_wdata;
      if (cfg_we && cfg_index == CfgDepthLimit) depth_limit_r <= cfg_wdata[6:0];
    end
    if (in_fire) begin
      mode_r <= in_tdata[1:0];
      key_r  <= in_tdata[129:2];
      uf_r   <= in_tdata[145:130];
      fm_r   <= in_tdata[161:146];
      ds_r   <= in_tdata[176:162];
    end
    cand_i_r  <= cand_i_nxt;
    alt_i_r   <= alt_i_nxt;
    phase_r   <= phase_nxt;
    pos_r     <= pos_nxt;
    cur_r     <= cur_nxt;
    alt_r     <= alt_nxt;
    child_r   <= child_nxt;
    d_r       <= d_nxt;
    ok_r      <= ok_nxt;
    unw_r     <= unw_nxt;
    cur_rec_r <= cur_rec_nxt;
    pop_rec_r <= pop_rec_nxt;
    drop_r    <= drop_nxt;
    odata_r   <= odata_nxt;
  end
endmodule

// ===== hdl/chte_checker.sv =====
// port-level checker for the cuckoo hash table engine
`include "cuckoo_hash_table_engine_macros.svh"
module chte_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [87:0]  out_tdata
);
  `CHT_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")
  `CHT_ASSERT_IMP(a_no_accept_pending, clk, rst_n, out_tvalid, !in_tready, "request taken while result pending")
  `CHT_ASSERT_IMP(a_status_range, clk, rst_n, out_tvalid, out_tdata[2:0] <= 3'd5, "status code out of range")
  `CHT_ASSERT_IMP(a_fill_range, clk, rst_n, out_tvalid, out_tdata[87:77] <= 11'd1024, "fill above table depth")
endmodule

bind cuckoo_hash_table_engine chte_checker u_chte_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== dv/cuckoo_hash_table_engine_tb.sv =====
// self-checking testbench for the four-way cuckoo hash table engine
module cuckoo_hash_table_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import chte_pkg::*;

  // one request as it travels on the input channel
  typedef struct {
    mode_t        mode;
    logic [127:0] key;
    logic [15:0]  user_flags;
    logic [15:0]  flag_mask;
    logic [14:0]  data_size;
  } request_t;

  // one result as it travels on the output channel
  typedef struct {
    logic [2:0]  status;
    logic [9:0]  slot;
    logic [31:0] seq;
    logic [15:0] flags;
    logic [14:0] size;
    logic        dropped;
    logic [10:0] fill;
  } answer_t;

  // directed row: request plus an optional typed-in answer
  typedef struct {
    request_t req;
    bit       typed;
    answer_t  ans;
  } row_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [183:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [87:0]  out_tdata;
  logic         cfg_we;
  logic [1:0]   cfg_index;
  logic [10:0]  cfg_wdata;

  cuckoo_hash_table_engine DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // shadow copy of the table contents and registers
  logic [127:0] shadow_key   [TableDepth];
  logic [31:0]  shadow_seq   [TableDepth];
  logic [15:0]  shadow_flags [TableDepth];
  logic [14:0]  shadow_size  [TableDepth];
  int           shadow_fill;
  logic [10:0]  slot_count_reg;
  logic [6:0]   evict_depth_reg;
  bit           drop_happened;
  int           chain_slots [MaxEvictDepth];

  answer_t      pending_results [$];
  int           error_count;
  bit           hold_off_req;
  logic [127:0] key_pool [24];

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit, far above the slowest correct run
  initial begin
    #48ms;
    $display("cuckoo_hash_table_engine_tb NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int live_slots();
    if (slot_count_reg == 0) return 1;
    if (slot_count_reg > TableDepth) return TableDepth;
    return int'(slot_count_reg);
  endfunction

  function automatic int live_depth();
    return (evict_depth_reg > MaxEvictDepth) ? MaxEvictDepth : int'(evict_depth_reg);
  endfunction

  function automatic int hash_pos(logic [31:0] w);
    return int'(w % live_slots());
  endfunction

  function automatic int alt_pos(int s, int i);
    return hash_pos(shadow_key[s][32*i +: 32]);
  endfunction

  function automatic void move_entry(int dst, int src);
    shadow_key[dst]   = shadow_key[src];
    shadow_seq[dst]   = shadow_seq[src];
    shadow_flags[dst] = shadow_flags[src];
    shadow_size[dst]  = shadow_size[src];
    shadow_key[src]   = '0;
    shadow_seq[src]   = '0;
    shadow_flags[src] = '0;
    shadow_size[src]  = '0;
  endfunction

  // relocate an occupant to any empty alternate slot
  function automatic bit relocate_to_empty(int cur);
    int p;
    for (int i = 0; i < 4; i++) begin
      p = alt_pos(cur, i);
      if (p != cur && shadow_key[p] == '0) begin
        move_entry(p, cur);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // overwrite the first non-sticky alternate occupant
  function automatic bit drop_into_alternate(int cur);
    int p;
    for (int i = 0; i < 4; i++) begin
      p = alt_pos(cur, i);
      if (p == cur || shadow_flags[p][FlagSticky]) continue;
      if (shadow_fill > 0) shadow_fill--;
      drop_happened = 1'b1;
      move_entry(p, cur);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // bounded chain through the first alternate, then unwind
  function automatic bit free_slot_by_eviction(int start);
    int cur;
    int lim;
    int lvl;
    int child;
    int p0;
    int idx;
    bit ok;
    cur = start;
    lim = live_depth();
    lvl = 0;
    while (1) begin
      if (lvl >= lim) begin
        ok = 1'b0;
        break;
      end
      if (relocate_to_empty(cur)) begin
        ok = 1'b1;
        break;
      end
      p0 = alt_pos(cur, 0);
      if (p0 != cur) begin
        chain_slots[lvl] = cur;
        cur = p0;
        lvl++;
        continue;
      end
      ok = drop_into_alternate(cur);
      break;
    end
    child = cur;
    while (lvl > 0) begin
      lvl--;
      idx = chain_slots[lvl];
      if (ok) move_entry(child, idx);
      else ok = drop_into_alternate(idx);
      child = idx;
    end
    return ok;
  endfunction

  function automatic bit locate_key(logic [127:0] key, output int at);
    int p;
    for (int i = 0; i < 4; i++) begin
      p = hash_pos(key[32*i +: 32]);
      if (shadow_key[p] == key) begin
        at = p;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // apply one request to the shadow table and return its result
  function automatic answer_t table_predict(request_t r);
    answer_t a;
    int      at;
    int      p;
    bit      report;
    bit      placed;
    a = '{default: '0};
    at = 0;
    report = 1'b0;
    placed = 1'b0;
    drop_happened = 1'b0;
    if (r.mode == MODE_WRITE && r.data_size > BlockBytes) begin
      a.status = ST_TOO_LARGE;
    end else if (r.key == '0) begin
      a.status = ST_ZERO_KEY;
    end else if (r.mode != MODE_WRITE) begin
      if (!locate_key(r.key, at)) begin
        a.status = ST_NOT_FOUND;
      end else begin
        report = 1'b1;
        if (r.mode == MODE_DELETE) begin
          shadow_key[at]   = '0;
          shadow_seq[at]   = '0;
          shadow_flags[at] = '0;
          shadow_size[at]  = '0;
          if (shadow_fill > 0) shadow_fill--;
        end else if (r.mode == MODE_FLAGS) begin
          shadow_flags[at] = (shadow_flags[at] & ~r.flag_mask) | (r.user_flags & r.flag_mask);
        end
      end
    end else begin
      // first empty or matching candidate wins
      for (int i = 0; i < 4 && !placed; i++) begin
        p = hash_pos(r.key[32*i +: 32]);
        if (shadow_key[p] == '0) begin
          shadow_fill++;
          shadow_seq[p] = '0;
        end else if (shadow_key[p] != r.key) begin
          continue;
        end else if (shadow_flags[p][FlagReadOnly]) begin
          a.status = ST_READ_ONLY;
          at = p;
          report = 1'b1;
          placed = 1'b1;
          break;
        end
        shadow_key[p]   = r.key;
        shadow_seq[p]   = shadow_seq[p] + 32'd1;
        shadow_flags[p] = r.user_flags;
        shadow_size[p]  = r.data_size;
        at = p;
        report = 1'b1;
        placed = 1'b1;
      end
      // otherwise try to free each candidate in turn
      for (int i = 0; i < 4 && !placed; i++) begin
        p = hash_pos(r.key[32*i +: 32]);
        if (free_slot_by_eviction(p)) begin
          shadow_key[p]   = r.key;
          shadow_seq[p]   = 32'd1;
          shadow_flags[p] = r.user_flags;
          shadow_size[p]  = r.data_size;
          shadow_fill++;
          at = p;
          report = 1'b1;
          placed = 1'b1;
        end
      end
      if (!placed) a.status = ST_FULL;
    end
    if (report) begin
      a.slot  = at[9:0];
      a.seq   = shadow_seq[at];
      a.flags = shadow_flags[at];
      a.size  = shadow_size[at];
    end
    a.dropped = drop_happened;
    a.fill    = shadow_fill[10:0];
    return a;
  endfunction

  // ---------------------------------------------------------------- checker

  // compare each taken result with the oldest expectation
  always @(posedge clk) begin
    answer_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with no expectation waiting: %h", out_tdata);
        error_count++;
      end else begin
        e = pending_results.pop_front();
        if (out_tdata[2:0] !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_tdata[2:0]);
          error_count++;
        end
        if (out_tdata[12:3] !== e.slot) begin
          $error("slot: expected %0d, got %0d", e.slot, out_tdata[12:3]);
          error_count++;
        end
        if (out_tdata[44:13] !== e.seq) begin
          $error("entry_seq: expected %0d, got %0d", e.seq, out_tdata[44:13]);
          error_count++;
        end
        if (out_tdata[60:45] !== e.flags) begin
          $error("entry_flags: expected %h, got %h", e.flags, out_tdata[60:45]);
          error_count++;
        end
        if (out_tdata[75:61] !== e.size) begin
          $error("entry_size: expected %0d, got %0d", e.size, out_tdata[75:61]);
          error_count++;
        end
        if (out_tdata[76] !== e.dropped) begin
          $error("dropped: expected %0d, got %0d", e.dropped, out_tdata[76]);
          error_count++;
        end
        if (out_tdata[87:77] !== e.fill) begin
          $error("fill: expected %0d, got %0d", e.fill, out_tdata[87:77]);
          error_count++;
        end
      end
    end
  end

  // receiver: random stall pattern, runs of full readiness, and a long
  // hold-off on request so the single output register backs up the input
  initial begin
    int run_len;
    int style;
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_off_req = 1'b0;
      end
      run_len = $urandom_range(1, 60);
      style = $urandom_range(0, 3);
      repeat (run_len) begin
        case (style)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 3) != 0);
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= ($urandom_range(0, 1) == 1);
        endcase
        @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------- sender

  int burst_left;

  // offer one item in the current burst, waiting out a gap between bursts
  task automatic send_item(request_t r, bit typed, answer_t typed_ans);
    answer_t predicted;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
      if (in_tvalid) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 25)) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, r.data_size, r.flag_mask, r.user_flags, r.key, r.mode};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // item taken at this edge
    predicted = table_predict(r);
    pending_results.push_back(typed ? typed_ans : predicted);
  endtask

  task automatic drain_results();
    if (in_tvalid) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    while (pending_results.size() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [10:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == CfgTableCount) slot_count_reg = val;
    else evict_depth_reg = val[6:0];
  endtask

  function automatic logic [127:0] rand_key();
    return {$urandom(), $urandom(), $urandom(), $urandom()};
  endfunction

  // keys mostly from a pool so hits, collisions and evictions happen
  function automatic request_t rand_request();
    request_t r;
    int pick;
    int kind;
    pick = $urandom_range(0, 99);
    if (pick < 80) r.key = key_pool[$urandom_range(0, 23)];
    else if (pick < 95) r.key = rand_key();
    else r.key = '0;
    kind = $urandom_range(0, 99);
    if (kind < 45) r.mode = MODE_WRITE;
    else if (kind < 65) r.mode = MODE_LOOKUP;
    else if (kind < 80) r.mode = MODE_DELETE;
    else r.mode = MODE_FLAGS;
    r.user_flags = $urandom();
    // keep read-only entries from freezing the pool
    if ($urandom_range(0, 3) != 0) r.user_flags[FlagReadOnly] = 1'b0;
    r.flag_mask = $urandom();
    r.data_size = ($urandom_range(0, 9) == 0) ? 15'($urandom())
                                             : 15'($urandom_range(0, BlockBytes));
    return r;
  endfunction

  function automatic row_t make_row(mode_t m, logic [127:0] k, logic [15:0] uf,
                                    logic [15:0] fm, logic [14:0] ds, bit typed,
                                    logic [2:0] st, logic [10:0] fill);
    row_t row;
    row.req   = '{m, k, uf, fm, ds};
    row.typed = typed;
    row.ans   = '{default: '0};
    row.ans.status = st;
    row.ans.fill   = fill;
    return row;
  endfunction

  // ---------------------------------------------------------------- main

  initial begin
    row_t         directed [$];
    logic [127:0] ones;
    int           phase_count [7];
    int           phase_depth [7];
    int           per_phase;
    ones = '1;
    phase_count = '{0, 4, 16, 2047, 8, 64, 1};
    phase_depth = '{1, 2, 4, 127, 0, 8, 64};
    error_count = 0;
    hold_off_req = 1'b0;
    burst_left = 0;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_index = CfgTableCount;
    cfg_wdata = '0;
    for (int s = 0; s < TableDepth; s++) begin
      shadow_key[s]   = '0;
      shadow_seq[s]   = '0;
      shadow_flags[s] = '0;
      shadow_size[s]  = '0;
    end
    shadow_fill = 0;
    slot_count_reg = 11'd1024;
    evict_depth_reg = 7'd64;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed part on the reset configuration; status-only rows are typed in
    directed.push_back(make_row(MODE_LOOKUP, ones, 16'h0, 16'h0, 15'd0, 1, ST_NOT_FOUND, 0));
    directed.push_back(make_row(MODE_WRITE, '0, 16'hffff, 16'h0, 15'd0, 1, ST_ZERO_KEY, 0));
    directed.push_back(make_row(MODE_WRITE, ones, 16'h0, 16'h0, 15'h7fff, 1, ST_TOO_LARGE, 0));
    // too large wins over zero key
    directed.push_back(make_row(MODE_WRITE, '0, 16'h0, 16'h0, 15'd16385, 1, ST_TOO_LARGE, 0));
    directed.push_back(make_row(MODE_DELETE, '0, 16'h0, 16'h0, 15'd0, 1, ST_ZERO_KEY, 0));
    directed.push_back(make_row(MODE_FLAGS, '0, 16'h0, 16'hffff, 15'd0, 1, ST_ZERO_KEY, 0));
    directed.push_back(make_row(MODE_LOOKUP, '0, 16'h0, 16'h0, 15'd0, 1, ST_ZERO_KEY, 0));
    directed.push_back(make_row(MODE_WRITE, ones, 16'h0, 16'h0, 15'd16384, 0, 0, 0));
    directed.push_back(make_row(MODE_WRITE, ones, 16'hfffc, 16'h0, 15'd1, 0, 0, 0));
    directed.push_back(make_row(MODE_FLAGS, ones, 16'hffff, 16'h0003, 15'd0, 0, 0, 0));
    // read-only entry refuses the write
    directed.push_back(make_row(MODE_WRITE, ones, 16'h0, 16'h0, 15'd5, 0, 0, 0));
    directed.push_back(make_row(MODE_LOOKUP, ones, 16'h0, 16'h0, 15'd0, 0, 0, 0));
    directed.push_back(make_row(MODE_FLAGS, ones, 16'h0, 16'hffff, 15'd0, 0, 0, 0));
    directed.push_back(make_row(MODE_DELETE, ones, 16'h0, 16'h0, 15'd0, 0, 0, 0));
    directed.push_back(make_row(MODE_DELETE, ones, 16'h0, 16'h0, 15'd0, 1, ST_NOT_FOUND, 0));
    directed.push_back(make_row(MODE_FLAGS, ones, 16'h1, 16'h1, 15'd0, 1, ST_NOT_FOUND, 0));
    // colliding keys force an eviction; the first key's word0 and word1 hash apart
    directed.push_back(make_row(MODE_WRITE, {32'd7, 32'd5, 32'd3, 32'd1}, 16'h1, 16'h0,
                                15'd100, 0, 0, 0));
    directed.push_back(make_row(MODE_WRITE, {96'd0, 32'd1}, 16'h0, 16'h0, 15'd0, 0, 0, 0));
    directed.push_back(make_row(MODE_WRITE, {32'd1, 96'd0}, 16'h2, 16'h0, 15'd0, 0, 0, 0));
    directed.push_back(make_row(MODE_LOOKUP, {32'd7, 32'd5, 32'd3, 32'd1}, 16'h0, 16'h0,
                                15'd0, 0, 0, 0));
    foreach (directed[i]) send_item(directed[i].req, directed[i].typed, directed[i].ans);

    // random phases, each on a fresh setting including the out-of-range extremes
    per_phase = 650 / 7;
    for (int ph = 0; ph < 7; ph++) begin
      drain_results();
      repeat (4) @(posedge clk);
      write_reg(CfgTableCount, 11'(phase_count[ph]));
      write_reg(CfgDepthLimit, 11'(phase_depth[ph]));
      foreach (key_pool[k]) key_pool[k] = rand_key();
      for (int n = 0; n < per_phase; n++) begin
        if (ph == 2 && n == 30) hold_off_req = 1'b1;
        if (ph == 5 && n == 40) drain_results();
        send_item(rand_request(), 1'b0, '{default: '0});
      end
    end

    drain_results();
    repeat (200) @(posedge clk);
    if (error_count == 0) begin
      $display("cuckoo_hash_table_engine_tb OK");
    end else begin
      $display("cuckoo_hash_table_engine_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== cuckoo_hash_table_engine.f =====
+incdir+hdl
hdl/chte_pkg.sv
hdl/chte_ram.sv
hdl/chte_mod.sv
hdl/cuckoo_hash_table_engine.sv
hdl/chte_checker.sv
dv/cuckoo_hash_table_engine_tb.sv
